### hw/rtl/stfis_pkg.sv
package stfis_pkg;

  // Default sizes of the slot table.
  localparam int DEF_DEPTH       = 256;
  localparam int DEF_VALUE_WIDTH = 32;

  // Port widths fixed by the interface.
  localparam int OP_W     = 2;
  localparam int PIDX_W   = 8;
  localparam int PVAL_W   = 32;
  localparam int STAT_W   = 2;
  localparam int PLIVE_W  = 9;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_GET = 2'd1;
  localparam logic [OP_W-1:0] OP_POP = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Status from the datapath to the controller, about the item in hand.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            hit;
  } stfis_sts_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              capture;
    logic              commit;
    logic              add_en;
    logic              pop_en;
    logic              sel_slot;
    logic              sel_zero;
    logic              show_value;
    logic [STAT_W-1:0] status;
  } stfis_cmd_t;

endpackage

### hw/rtl/stfis_ctrl.sv
module stfis_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  stfis_pkg::stfis_sts_t sts,
  output stfis_pkg::stfis_cmd_t cmd
);
  import stfis_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r == S_EXEC);

  // Decide what the item does once the memory reads are back.
  always_comb begin
    cmd            = '0;
    cmd.capture    = start && (state_r == S_IDLE);
    cmd.commit     = (state_r == S_EXEC);
    cmd.status     = STAT_OK;
    if (state_r == S_EXEC) begin
      unique case (sts.op)
        OP_ADD: begin
          if (sts.full) begin
            cmd.sel_zero = 1'b1;
            cmd.status   = STAT_FULL;
          end else begin
            cmd.add_en   = 1'b1;
            cmd.sel_slot = 1'b1;
          end
        end
        OP_GET: begin
          cmd.show_value = sts.hit;
        end
        OP_POP: begin
          if (sts.hit) begin
            cmd.pop_en     = 1'b1;
            cmd.show_value = 1'b1;
          end else begin
            cmd.status = STAT_EMPTY;
          end
        end
        default: begin
          cmd.status = STAT_OK;
        end
      endcase
    end
  end

endmodule

### hw/rtl/stfis_dpath.sv
module stfis_dpath #(
  parameter int DEPTH       = stfis_pkg::DEF_DEPTH,
  parameter int VALUE_WIDTH = stfis_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [stfis_pkg::OP_W-1:0]          in_operation,
  input  logic [stfis_pkg::PIDX_W-1:0]        in_slot_index,
  input  logic [stfis_pkg::PVAL_W-1:0]        in_element_value,
  input  stfis_pkg::stfis_cmd_t               cmd,
  output stfis_pkg::stfis_sts_t               sts,
  output logic                                out_strobe,
  output logic [stfis_pkg::PIDX_W-1:0]        out_result_index,
  output logic [stfis_pkg::PVAL_W-1:0]        out_result_value,
  output logic                                out_slot_was_valid,
  output logic [stfis_pkg::STAT_W-1:0]        out_status,
  output logic [stfis_pkg::PLIVE_W-1:0]       out_live_entries
);
  import stfis_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Slot memory: valid bit on top of the element value.
  logic [VALUE_WIDTH:0] slot_mem [DEPTH];
  logic [IDX_W-1:0]     stack_mem [DEPTH];

  logic [VALUE_WIDTH:0] slot_rd_r;
  logic [IDX_W-1:0]     stack_rd_r;

  logic [OP_W-1:0]        op_r;
  logic [PIDX_W-1:0]      idx_r;
  logic [IDX_W-1:0]       idx_mem_r;
  logic                   in_range_r;
  logic [VALUE_WIDTH-1:0] val_r;

  logic [CNT_W-1:0] live_r;
  logic [CNT_W-1:0] live_nxt;
  logic [CNT_W-1:0] free_r;
  logic [CNT_W-1:0] free_nxt;

  logic [63:0]            in_val_ext;
  logic [IDX_W-1:0]       in_idx_mem;
  logic                   in_range;
  logic [CNT_W-1:0]       free_dec;
  logic [CNT_W:0]         high_water;
  logic [IDX_W-1:0]       add_slot;
  logic [31:0]            add_slot_ext;
  logic [63:0]            rd_val_ext;
  logic [31:0]            live_ext;

  logic                   strobe_r;
  logic [PIDX_W-1:0]      res_idx_r;
  logic [PVAL_W-1:0]      res_val_r;
  logic                   res_valid_r;
  logic [STAT_W-1:0]      res_stat_r;
  logic [PLIVE_W-1:0]     res_live_r;

  assign in_val_ext = 64'(in_element_value);
  assign in_idx_mem = IDX_W'(in_slot_index);
  assign in_range   = 32'(in_slot_index) < DEPTH;
  assign free_dec   = free_r - CNT_W'(1);

  // Capture the item and start both memory reads.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_operation;
      idx_r      <= in_slot_index;
      idx_mem_r  <= in_idx_mem;
      in_range_r <= in_range;
      val_r      <= in_val_ext[VALUE_WIDTH-1:0];
      slot_rd_r  <= slot_mem[in_idx_mem];
      stack_rd_r <= stack_mem[free_dec[IDX_W-1:0]];
    end
  end

  // Slots at or beyond the high-water mark have never been written.
  assign high_water = {1'b0, live_r} + {1'b0, free_r};
  assign add_slot   = (free_r != '0) ? stack_rd_r : live_r[IDX_W-1:0];

  assign sts.op   = op_r;
  assign sts.full = (live_r == CNT_W'(DEPTH));
  assign sts.hit  = in_range_r && ((CNT_W+1)'(idx_mem_r) < high_water) && slot_rd_r[VALUE_WIDTH];

  always_comb begin
    live_nxt = live_r;
    free_nxt = free_r;
    if (cmd.add_en) begin
      live_nxt = live_r + CNT_W'(1);
      if (free_r != '0) begin
        free_nxt = free_dec;
      end
    end else if (cmd.pop_en) begin
      live_nxt = live_r - CNT_W'(1);
      if (free_r < CNT_W'(DEPTH)) begin
        free_nxt = free_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      free_r <= '0;
    end else begin
      live_r <= live_nxt;
      free_r <= free_nxt;
    end
  end

  // Write back: add marks a slot valid, pop clears it and stacks its index.
  always_ff @(posedge clk) begin
    if (cmd.add_en) begin
      slot_mem[add_slot] <= {1'b1, val_r};
    end else if (cmd.pop_en) begin
      slot_mem[idx_mem_r] <= {1'b0, slot_rd_r[VALUE_WIDTH-1:0]};
      if (free_r < CNT_W'(DEPTH)) begin
        stack_mem[free_r[IDX_W-1:0]] <= idx_mem_r;
      end
    end
  end

  assign add_slot_ext = 32'(add_slot);
  assign rd_val_ext   = 64'(slot_rd_r[VALUE_WIDTH-1:0]);
  assign live_ext     = 32'(live_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (cmd.sel_zero) begin
        res_idx_r <= '0;
      end else if (cmd.sel_slot) begin
        res_idx_r <= add_slot_ext[PIDX_W-1:0];
      end else begin
        res_idx_r <= idx_r;
      end
      res_val_r   <= cmd.show_value ? rd_val_ext[PVAL_W-1:0] : '0;
      res_valid_r <= cmd.show_value;
      res_stat_r  <= cmd.status;
      res_live_r  <= live_ext[PLIVE_W-1:0];
    end
  end

  assign out_strobe         = strobe_r;
  assign out_result_index   = res_idx_r;
  assign out_result_value   = res_val_r;
  assign out_slot_was_valid = res_valid_r;
  assign out_status         = res_stat_r;
  assign out_live_entries   = res_live_r;

endmodule

### hw/rtl/slot_table_with_free_index_stack_core.sv
// Slot table with a stack of freed slot indexes. Raise start with an
// operation (add, get or pop) while busy is low; the item is taken at that
// edge, and the slot memory and the free-index stack are read at the same
// edge. Busy is then high for one cycle while the words that were read are
// decoded. At the edge that ends that cycle the memories are written back
// and the result is registered. The result is shown on the out_ ports in
// the cycle straight after that edge, with out_strobe high for exactly one
// cycle. The receiver cannot stall it, so it must take every result when it
// is shown. No new item is taken while busy is high, since each item has the
// single-port slot memory read and then written back. A new item may be
// started in the very cycle that the previous result is shown. No clearing
// pass is needed after reset: the table tracks how many slots have ever
// been used (live count plus the depth of the free stack), and any slot
// beyond that mark reads as empty. An add to a full table is refused with
// the full status and changes nothing; a pop of an empty or out-of-range
// slot is refused with the empty status. Element values are kept to
// VALUE_WIDTH bits.
module slot_table_with_free_index_stack_core #(
  parameter int DEPTH       = stfis_pkg::DEF_DEPTH,
  parameter int VALUE_WIDTH = stfis_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [stfis_pkg::OP_W-1:0]    in_operation,
  input  logic [stfis_pkg::PIDX_W-1:0]  in_slot_index,
  input  logic [stfis_pkg::PVAL_W-1:0]  in_element_value,
  output logic                          out_strobe,
  output logic [stfis_pkg::PIDX_W-1:0]  out_result_index,
  output logic [stfis_pkg::PVAL_W-1:0]  out_result_value,
  output logic                          out_slot_was_valid,
  output logic [stfis_pkg::STAT_W-1:0]  out_status,
  output logic [stfis_pkg::PLIVE_W-1:0] out_live_entries
);
  import stfis_pkg::*;

  // Commands flow from the controller, status about the item flows back.
  stfis_cmd_t cmd;
  stfis_sts_t sts;

  stfis_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  stfis_dpath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_operation       (in_operation),
    .in_slot_index      (in_slot_index),
    .in_element_value   (in_element_value),
    .cmd                (cmd),
    .sts                (sts),
    .out_strobe         (out_strobe),
    .out_result_index   (out_result_index),
    .out_result_value   (out_result_value),
    .out_slot_was_valid (out_slot_was_valid),
    .out_status         (out_status),
    .out_live_entries   (out_live_entries)
  );

endmodule

### hw/rtl/stfis_chk.sv
module stfis_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_strobe,
  input logic [stfis_pkg::PIDX_W-1:0]  out_result_index,
  input logic [stfis_pkg::PVAL_W-1:0]  out_result_value,
  input logic                          out_slot_was_valid,
  input logic [stfis_pkg::STAT_W-1:0]  out_status
);
  import stfis_pkg::*;

  // An accepted item is followed by one busy cycle and then its result.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted item");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("no result two cycles after an accepted item");

  a_strobe_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result shown without an item in progress");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == STAT_FULL) |->
      (out_result_index == '0 && !out_slot_was_valid && out_result_value == '0))
    else $error("refused add reported a slot");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == STAT_EMPTY) |->
      (!out_slot_was_valid && out_result_value == '0))
    else $error("refused pop reported a value");

endmodule

bind slot_table_with_free_index_stack_core stfis_chk u_stfis_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_strobe         (out_strobe),
  .out_result_index   (out_result_index),
  .out_result_value   (out_result_value),
  .out_slot_was_valid (out_slot_was_valid),
  .out_status         (out_status)
);

### tb/tb_slot_table_with_free_index_stack_core.sv
`timescale 1ns / 100ps

// Self-checking bench for the slot table with its stack of freed indexes.
// One clocked process drives the command channel, predicts the result of
// every accepted item and checks the result channel. Keeping all three in
// one process means the prediction always sees the state left by the
// previous item, and the choice of the next item can look at that state
// without any ordering hazard between processes.
module tb_slot_table_with_free_index_stack_core;
  import stfis_pkg::*;

  localparam int DEPTH       = DEF_DEPTH;
  localparam int VALUE_WIDTH = DEF_VALUE_WIDTH;
  localparam logic [PVAL_W-1:0] VALUE_MASK = {PVAL_W{1'b1}} >> (PVAL_W - VALUE_WIDTH);

  // The fourth operation code does nothing and has no name in the package.
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  localparam int N_DIRECTED    = 24;
  localparam int N_RANDOM      = 1950;
  localparam int N_ITEMS       = N_DIRECTED + N_RANDOM;
  localparam int PHASE_LEN     = 325;
  // Items in this window are offered back to back, with no idle cycles.
  localparam int CALM_FIRST    = N_DIRECTED + 700;
  localparam int CALM_LAST     = N_DIRECTED + 1000;
  localparam int IDLE_PERCENT  = 37;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;

  // The random part runs in phases of PHASE_LEN items: filling the table,
  // a balanced mix, draining it, then a balanced mix again, and so on.
  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} op_mix_t;

  typedef struct packed {
    logic [PIDX_W-1:0]  index;
    logic [PVAL_W-1:0]  value;
    logic               valid;
    logic [STAT_W-1:0]  status;
    logic [PLIVE_W-1:0] live;
  } slot_result_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PIDX_W-1:0] index;
    logic [PVAL_W-1:0] value;
    logic              typed;
    slot_result_t      want;
  } stim_row_t;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                start            = 1'b0;
  logic [OP_W-1:0]     in_operation     = OP_ADD;
  logic [PIDX_W-1:0]   in_slot_index    = '0;
  logic [PVAL_W-1:0]   in_element_value = '0;
  logic                busy;
  logic                out_strobe;
  logic [PIDX_W-1:0]   out_result_index;
  logic [PVAL_W-1:0]   out_result_value;
  logic                out_slot_was_valid;
  logic [STAT_W-1:0]   out_status;
  logic [PLIVE_W-1:0]  out_live_entries;

  slot_table_with_free_index_stack_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_slot_index      (in_slot_index),
    .in_element_value   (in_element_value),
    .out_strobe         (out_strobe),
    .out_result_index   (out_result_index),
    .out_result_value   (out_result_value),
    .out_slot_was_valid (out_slot_was_valid),
    .out_status         (out_status),
    .out_live_entries   (out_live_entries)
  );

  always #5 clk = ~clk;

  // Shadow copy of the table, kept by the predictor. Values of slots that
  // were never written are never looked at, so they need no reset.
  logic [PVAL_W-1:0] tbl_value [DEPTH];
  logic              tbl_held  [DEPTH] = '{default: 1'b0};
  logic [PIDX_W-1:0] freed_idx [DEPTH];
  int unsigned       freed_cnt = 0;
  int unsigned       held_cnt  = 0;

  slot_result_t pending_results [$];
  stim_row_t    directed_rows [N_DIRECTED];
  stim_row_t    cur_item;
  int           row_fill       = 0;
  int           items_sent     = 0;
  int           results_seen   = 0;
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  int           settle_count   = 0;
  logic         run_done       = 1'b0;
  logic         timed_out      = 1'b0;

  // Applies one item to the shadow table and returns the result it causes.
  function automatic slot_result_t apply_slot_op(input logic [OP_W-1:0] op,
                                                 input logic [PIDX_W-1:0] idx,
                                                 input logic [PVAL_W-1:0] val);
    slot_result_t      res;
    logic [PIDX_W-1:0] slot;
    logic              hit;
    hit = (int'(idx) < DEPTH) && tbl_held[idx];
    res.index  = idx;
    res.value  = '0;
    res.valid  = 1'b0;
    res.status = STAT_OK;
    case (op)
      OP_ADD: begin
        if (held_cnt >= DEPTH) begin
          res.index  = '0;
          res.status = STAT_FULL;
        end else begin
          // The most recently freed slot is reused first; otherwise the
          // lowest slot that has never been used is taken.
          if (freed_cnt > 0) begin
            freed_cnt--;
            slot = freed_idx[freed_cnt];
          end else begin
            slot = PIDX_W'(held_cnt);
          end
          tbl_value[slot] = val & VALUE_MASK;
          tbl_held[slot]  = 1'b1;
          held_cnt++;
          res.index = slot;
        end
      end
      OP_GET: begin
        if (hit) begin
          res.value = tbl_value[idx];
          res.valid = 1'b1;
        end
      end
      OP_POP: begin
        if (!hit) begin
          res.status = STAT_EMPTY;
        end else begin
          res.value     = tbl_value[idx];
          res.valid     = 1'b1;
          tbl_held[idx] = 1'b0;
          if (held_cnt > 0) held_cnt--;
          if (freed_cnt < DEPTH) begin
            freed_idx[freed_cnt] = idx;
            freed_cnt++;
          end
        end
      end
      default: ;
    endcase
    res.live = PLIVE_W'(held_cnt);
    return res;
  endfunction

  // Directed row whose result is written out by hand.
  task automatic row_typed(input logic [OP_W-1:0] op, input logic [PIDX_W-1:0] idx,
                           input logic [PVAL_W-1:0] val, input logic [PIDX_W-1:0] r_idx,
                           input logic [PVAL_W-1:0] r_val, input logic r_valid,
                           input logic [STAT_W-1:0] r_stat, input logic [PLIVE_W-1:0] r_live);
    stim_row_t row;
    row.op          = op;
    row.index       = idx;
    row.value       = val;
    row.typed       = 1'b1;
    row.want.index  = r_idx;
    row.want.value  = r_val;
    row.want.valid  = r_valid;
    row.want.status = r_stat;
    row.want.live   = r_live;
    directed_rows[row_fill] = row;
    row_fill++;
  endtask

  // Directed row whose result is left to the predictor.
  task automatic row_pred(input logic [OP_W-1:0] op, input logic [PIDX_W-1:0] idx,
                          input logic [PVAL_W-1:0] val);
    stim_row_t row;
    row.op    = op;
    row.index = idx;
    row.value = val;
    row.typed = 1'b0;
    row.want  = '0;
    directed_rows[row_fill] = row;
    row_fill++;
  endtask

  task automatic flag_mismatch(input int n, input string field, input logic [31:0] got,
                               input logic [31:0] wanted);
    $display("result %0d: %s is %0h, expected %0h", n, field, got, wanted);
    mismatch_count++;
  endtask

  // Drive, predict and check, all at the rising edge. Every read of a DUT
  // output or of start here sees the value from before the edge.
  always @(posedge clk) begin : drive_and_check
    slot_result_t want;
    stim_row_t    nxt;
    logic         next_start;
    logic         found;
    int           pick;
    int           slot_try;
    int           t_add;
    int           t_get;
    int           t_pop;
    int           phase;
    op_mix_t      mix;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) timed_out = 1'b1;
    if (rst_n) begin
      // Results cannot be held off, so every strobe is checked when shown.
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          flag_mismatch(results_seen, "result with nothing pending, index",
                        32'(out_result_index), '0);
        end else begin
          want = pending_results.pop_front();
          if (out_result_index !== want.index)
            flag_mismatch(results_seen, "result_index", 32'(out_result_index),
                          32'(want.index));
          if (out_result_value !== want.value)
            flag_mismatch(results_seen, "result_value", out_result_value, want.value);
          if (out_slot_was_valid !== want.valid)
            flag_mismatch(results_seen, "slot_was_valid", 32'(out_slot_was_valid),
                          32'(want.valid));
          if (out_status !== want.status)
            flag_mismatch(results_seen, "status", 32'(out_status), 32'(want.status));
          if (out_live_entries !== want.live)
            flag_mismatch(results_seen, "live_entries", 32'(out_live_entries),
                          32'(want.live));
        end
        results_seen++;
      end

      // An item is taken at an edge where start is high and busy is low.
      // The predictor always runs so that its state follows the block, even
      // on rows that carry a hand-written result.
      next_start = start;
      if (start && !busy) begin
        want = apply_slot_op(cur_item.op, cur_item.index, cur_item.value);
        pending_results.push_back(cur_item.typed ? cur_item.want : want);
        items_sent++;
        next_start = 1'b0;
      end

      // Offer the next item, or leave a random idle cycle. Because start is
      // only assigned once below, an item that follows straight on keeps
      // start high without a glitch.
      if (!next_start && items_sent < N_ITEMS) begin
        if ((items_sent >= CALM_FIRST && items_sent < CALM_LAST) ||
            $urandom_range(99) >= IDLE_PERCENT) begin
          if (items_sent < N_DIRECTED) begin
            nxt = directed_rows[items_sent];
          end else begin
            phase = (items_sent - N_DIRECTED) / PHASE_LEN;
            if (phase % 2 == 1) mix = MIX_BALANCED;
            else if (phase % 4 == 0) mix = MIX_FILL;
            else mix = MIX_DRAIN;
            case (mix)
              MIX_FILL: begin
                t_add = 88; t_get = 94; t_pop = 99;
              end
              MIX_DRAIN: begin
                t_add = 7; t_get = 22; t_pop = 97;
              end
              default: begin
                t_add = 40; t_get = 70; t_pop = 97;
              end
            endcase
            pick = $urandom_range(99);
            if (pick < t_add) nxt.op = OP_ADD;
            else if (pick < t_get) nxt.op = OP_GET;
            else if (pick < t_pop) nxt.op = OP_POP;
            else nxt.op = OP_NONE;
            nxt.index = PIDX_W'($urandom);
            // Most gets and pops aim at an occupied slot, so that pops
            // actually free slots and the free stack gets deep.
            if ((nxt.op == OP_GET || nxt.op == OP_POP) && held_cnt > 0 &&
                $urandom_range(99) < 80) begin
              found    = 1'b0;
              slot_try = $urandom_range(DEPTH - 1);
              for (int k = 0; k < DEPTH; k++) begin
                if (!found && tbl_held[(slot_try + k) % DEPTH]) begin
                  nxt.index = PIDX_W'((slot_try + k) % DEPTH);
                  found     = 1'b1;
                end
              end
            end
            case ($urandom_range(9))
              0:       nxt.value = '0;
              1:       nxt.value = '1;
              default: nxt.value = $urandom;
            endcase
            nxt.typed = 1'b0;
            nxt.want  = '0;
          end
          cur_item         = nxt;
          next_start       = 1'b1;
          in_operation     <= nxt.op;
          in_slot_index    <= nxt.index;
          in_element_value <= nxt.value;
        end
      end
      start <= next_start;

      // Once every item is in and every result is back, let the settle count run
      // out, watching for any stray strobe, before ending the run.
      if (items_sent == N_ITEMS && pending_results.size() == 0) begin
        settle_count++;
        if (settle_count >= SETTLE_CYCLES) run_done = 1'b1;
      end
    end
  end

  initial begin
    // The hand-written results follow from an empty table after reset:
    // fresh slots are handed out from zero upwards and the last freed slot
    // is the first to be reused.
    row_typed(OP_GET,  8'd0,   32'h0000_0000, 8'd0,   32'h0000_0000, 1'b0, STAT_OK,    9'd0);
    row_typed(OP_POP,  8'd255, 32'h0000_0000, 8'd255, 32'h0000_0000, 1'b0, STAT_EMPTY, 9'd0);
    row_typed(OP_NONE, 8'hAA,  32'hFFFF_FFFF, 8'hAA,  32'h0000_0000, 1'b0, STAT_OK,    9'd0);
    row_typed(OP_ADD,  8'h55,  32'h0000_0000, 8'd0,   32'h0000_0000, 1'b0, STAT_OK,    9'd1);
    row_typed(OP_ADD,  8'hFF,  32'hFFFF_FFFF, 8'd1,   32'h0000_0000, 1'b0, STAT_OK,    9'd2);
    row_typed(OP_ADD,  8'h00,  32'h1234_5678, 8'd2,   32'h0000_0000, 1'b0, STAT_OK,    9'd3);
    row_typed(OP_GET,  8'd1,   32'h0000_0000, 8'd1,   32'hFFFF_FFFF, 1'b1, STAT_OK,    9'd3);
    row_typed(OP_GET,  8'd0,   32'hFFFF_FFFF, 8'd0,   32'h0000_0000, 1'b1, STAT_OK,    9'd3);
    row_typed(OP_POP,  8'd1,   32'h0000_0000, 8'd1,   32'hFFFF_FFFF, 1'b1, STAT_OK,    9'd2);
    row_typed(OP_POP,  8'd1,   32'h0000_0000, 8'd1,   32'h0000_0000, 1'b0, STAT_EMPTY, 9'd2);
    row_pred(OP_GET,  8'd1,   32'h0000_0000);
    row_pred(OP_POP,  8'd0,   32'h0000_0000);
    row_pred(OP_GET,  8'd2,   32'h0000_0000);
    row_pred(OP_ADD,  8'd0,   32'hA5A5_A5A5);
    row_pred(OP_ADD,  8'd0,   32'h5A5A_5A5A);
    row_pred(OP_ADD,  8'd0,   32'h8000_0001);
    row_pred(OP_POP,  8'd3,   32'h0000_0000);
    row_pred(OP_POP,  8'd2,   32'h0000_0000);
    row_pred(OP_ADD,  8'd0,   32'hDEAD_BEEF);
    row_pred(OP_GET,  8'd255, 32'h0000_0000);
    row_pred(OP_POP,  8'd0,   32'h0000_0000);
    row_pred(OP_NONE, 8'd0,   32'h0000_0000);
    row_pred(OP_GET,  8'd3,   32'h0000_0000);
    row_pred(OP_ADD,  8'd0,   32'h0000_0001);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (run_done || timed_out);
    if (timed_out) begin
      $display("tb_slot_table_with_free_index_stack_core failed");
    end else if (mismatch_count == 0) begin
      $display("tb_slot_table_with_free_index_stack_core passed");
    end else begin
      $display("tb_slot_table_with_free_index_stack_core failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/stfis_pkg.sv
hw/rtl/stfis_ctrl.sv
hw/rtl/stfis_dpath.sv
hw/rtl/slot_table_with_free_index_stack_core.sv
hw/rtl/stfis_chk.sv
tb/tb_slot_table_with_free_index_stack_core.sv
